// ----- rtl/pip_pkg.sv -----
`default_nettype none

package pip_pkg;

  localparam int COORD_W = 16;
  localparam int DIFF_W  = COORD_W + 1;
  localparam int PROD_W  = 2 * DIFF_W;

  typedef logic signed [COORD_W-1:0] coord_t;
  typedef logic signed [DIFF_W-1:0]  diff_t;
  typedef logic signed [PROD_W-1:0]  prod_t;

  // One accepted edge transaction, as captured at the input register.
  typedef struct packed {
    coord_t point_x;
    coord_t point_y;
    coord_t edge_ax;
    coord_t edge_ay;
    coord_t edge_bx;
    coord_t edge_by;
    logic   last_edge;
  } edge_raw_t;

  // Products and flags handed from the multiply stage to the accumulator.
  typedef struct packed {
    prod_t lhs;       // (px - ax) * (by - ay)
    prod_t rhs;       // (py - ay) * (bx - ax)
    logic  straddle;  // half-open y straddle
    logic  b_above;   // by > py; with straddle set, equals dy > 0
    logic  last_edge;
  } edge_prod_t;

endpackage

`default_nettype wire

// ----- rtl/pip_edge_mult.sv -----
`default_nettype none

module pip_edge_mult
  import pip_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       in_valid,
  output logic            in_ready,
  input  wire edge_raw_t  in_data,
  output logic            prod_valid,
  input  wire logic       prod_ready,
  output edge_prod_t      prod_data
);

  logic       raw_valid;
  edge_raw_t  raw;
  logic       raw_en;
  logic       prod_en;
  diff_t      dx, dy, ey, ex;
  logic       a_above, b_above;
  edge_prod_t prod_next;

  assign prod_en  = !prod_valid || prod_ready;
  assign raw_en   = !raw_valid || prod_en;
  assign in_ready = raw_en;

  // Differences are one bit wider than the coordinates, so they never wrap.
  assign dx = {raw.point_x[COORD_W-1], raw.point_x} - {raw.edge_ax[COORD_W-1], raw.edge_ax};
  assign dy = {raw.edge_by[COORD_W-1], raw.edge_by} - {raw.edge_ay[COORD_W-1], raw.edge_ay};
  assign ey = {raw.point_y[COORD_W-1], raw.point_y} - {raw.edge_ay[COORD_W-1], raw.edge_ay};
  assign ex = {raw.edge_bx[COORD_W-1], raw.edge_bx} - {raw.edge_ax[COORD_W-1], raw.edge_ax};

  assign a_above = raw.edge_ay > raw.point_y;
  assign b_above = raw.edge_by > raw.point_y;

  always_comb begin
    prod_next.lhs       = prod_t'(dx) * prod_t'(dy);
    prod_next.rhs       = prod_t'(ey) * prod_t'(ex);
    prod_next.straddle  = a_above ^ b_above;
    prod_next.b_above   = b_above;
    prod_next.last_edge = raw.last_edge;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      raw_valid  <= 1'b0;
      prod_valid <= 1'b0;
    end else begin
      if (raw_en) begin
        raw_valid <= in_valid;
      end
      if (prod_en) begin
        prod_valid <= raw_valid;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (raw_en && in_valid) begin
      raw <= in_data;
    end
    if (prod_en && raw_valid) begin
      prod_data <= prod_next;
    end
  end

endmodule

`default_nettype wire

// ----- rtl/pip_accum.sv -----
`default_nettype none

module pip_accum
  import pip_pkg::*;
#(
  parameter int MAX_EDGES = 1024,
  parameter int CNT_W     = $clog2(MAX_EDGES + 1)
) (
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         prod_valid,
  output logic              prod_ready,
  input  wire edge_prod_t   prod_data,
  output logic              out_valid,
  input  wire logic         out_ready,
  output logic              inside_res,
  output logic [CNT_W-1:0]  crossing_count
);

  localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_EDGES);

  logic             parity;
  logic [CNT_W-1:0] count;
  logic             parity_next;
  logic [CNT_W-1:0] count_next;
  logic             crosses;
  logic             take;

  // A last edge needs the result register; other edges never stall here.
  assign prod_ready = !prod_data.last_edge || !out_valid || out_ready;
  assign take       = prod_valid && prod_ready;

  // Sign of dy flips the cross-multiplied comparison.
  always_comb begin
    if (prod_data.b_above) begin
      crosses = prod_data.straddle && (prod_data.lhs <= prod_data.rhs);
    end else begin
      crosses = prod_data.straddle && (prod_data.lhs >= prod_data.rhs);
    end
    parity_next = parity ^ crosses;
    count_next  = (crosses && (count < CNT_MAX)) ? count + CNT_W'(1) : count;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      parity    <= 1'b0;
      count     <= '0;
      out_valid <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
      if (take) begin
        if (prod_data.last_edge) begin
          out_valid <= 1'b1;
          parity    <= 1'b0;
          count     <= '0;
        end else begin
          parity <= parity_next;
          count  <= count_next;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take && prod_data.last_edge) begin
      inside_res     <= parity_next;
      crossing_count <= count_next;
    end
  end

endmodule

`default_nettype wire

// ----- rtl/point_in_polygon_parity.sv -----
// Channel | Signals                                         | Direction
// edge    | in_valid, in_ready, point_x/y, edge_ax/ay/bx/by, | into block
//         | last_edge                                        |
// result  | out_valid, out_ready, inside_res, crossing_count | out of block
//
// One edge transaction per cycle while in_ready is high. An accepted last edge
// loads the input register, then the product register, then the result register,
// which raises out_valid; back-pressure can hold it in the input or product register.
// The two 17x17 products in the middle stage set the cycle time.
// Reset (rst, synchronous) empties all stages and clears parity and count.
// A waiting result holds only a following last edge in the product register;
// edges behind it back up into the input register and then drop in_ready.
`default_nettype none

module point_in_polygon_parity
  import pip_pkg::*;
#(
  parameter int MAX_EDGES = 1024
) (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire logic                           in_valid,
  output logic                                in_ready,
  input  wire logic signed [COORD_W-1:0]      point_x,
  input  wire logic signed [COORD_W-1:0]      point_y,
  input  wire logic signed [COORD_W-1:0]      edge_ax,
  input  wire logic signed [COORD_W-1:0]      edge_ay,
  input  wire logic signed [COORD_W-1:0]      edge_bx,
  input  wire logic signed [COORD_W-1:0]      edge_by,
  input  wire logic                           last_edge,
  output logic                                out_valid,
  input  wire logic                           out_ready,
  output logic                                inside_res,
  output logic [$clog2(MAX_EDGES + 1)-1:0]    crossing_count
);

  localparam int CNT_W = $clog2(MAX_EDGES + 1);

  edge_raw_t  in_data;
  edge_prod_t prod_data;
  logic       prod_valid;
  logic       prod_ready;

  // Bundle the edge transaction for the input register.
  always_comb begin
    in_data.point_x   = point_x;
    in_data.point_y   = point_y;
    in_data.edge_ax   = edge_ax;
    in_data.edge_ay   = edge_ay;
    in_data.edge_bx   = edge_bx;
    in_data.edge_by   = edge_by;
    in_data.last_edge = last_edge;
  end

  // Register the edge, form differences, multiply and register products.
  pip_edge_mult u_mult (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_data    (in_data),
    .prod_valid (prod_valid),
    .prod_ready (prod_ready),
    .prod_data  (prod_data)
  );

  // Compare products, advance parity and saturating count, emit on last edge.
  pip_accum #(
    .MAX_EDGES (MAX_EDGES),
    .CNT_W     (CNT_W)
  ) u_accum (
    .clk            (clk),
    .rst            (rst),
    .prod_valid     (prod_valid),
    .prod_ready     (prod_ready),
    .prod_data      (prod_data),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .inside_res     (inside_res),
    .crossing_count (crossing_count)
  );

`ifndef SYNTH
  // Count never passes the saturation limit.
  a_count_limit: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (crossing_count <= CNT_W'(MAX_EDGES)))
    else $error("crossing_count above MAX_EDGES");

  // Below saturation, parity and count agree.
  a_parity_count: assert property (@(posedge clk) disable iff (rst)
    (out_valid && (crossing_count < CNT_W'(MAX_EDGES))) |->
      (inside_res == crossing_count[0]))
    else $error("inside_res disagrees with crossing_count");

  // Product and result registers are empty right after reset.
  a_reset_empty: assert property (@(posedge clk)
    rst |=> (!out_valid && !prod_valid))
    else $error("pipeline not empty after reset");
`endif

endmodule

`default_nettype wire
